### src/box_mean_filter_stream_core_assert.svh
// ---------------------------------------------------------------------------
// Box mean filter assertion macros
// Shared concurrent assertion forms for the box mean filter core.
// ---------------------------------------------------------------------------
`ifndef BOX_MEAN_FILTER_STREAM_CORE_ASSERT_SVH
`define BOX_MEAN_FILTER_STREAM_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/bmf_pkg.sv
// ---------------------------------------------------------------------------
// Box mean filter package
// Widths, register codes, shared structs and the reciprocal table.
// ---------------------------------------------------------------------------
package bmf_pkg;

   localparam int MAX_WINDOW  = 7;
   localparam int MAX_WIDTH   = 1024;
   localparam int LANES       = MAX_WINDOW - 1;
   localparam int PIX_W       = 8;
   localparam int N_W         = 3;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WIDTH_W     = 11;
   localparam int ROW_W       = 16;
   localparam int CS_W        = PIX_W + $clog2(MAX_WINDOW);
   localparam int SUM_W       = CS_W + $clog2(MAX_WINDOW);
   localparam int RECIP_SHIFT = SUM_W + $clog2(MAX_WINDOW * MAX_WINDOW);
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int CNT_W       = FIFO_AW + 1;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_FIELD_W = PIX_W + ROW_W + COL_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_SIZE  = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             emit;
      logic [N_W-1:0]   n;
      logic [ROW_W-1:0] center_row;
      logic [COL_W-1:0] center_col;
      logic             last;
   } ctl_type;

   typedef struct packed {
      logic [PIX_W-1:0] mean;
      logic [ROW_W-1:0] center_row;
      logic [COL_W-1:0] center_col;
      logic             last;
   } result_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

   // ceil(2^RECIP_SHIFT / (n*n)); exact truncating division for sums below 2^SUM_W.
   function automatic logic [RECIP_W-1:0] recip(input logic [N_W-1:0] n);
      logic [RECIP_W-1:0] m;
      case (n)
         3'd2:    m = 21'd262144;
         3'd3:    m = 21'd116509;
         3'd4:    m = 21'd65536;
         3'd5:    m = 21'd41944;
         3'd6:    m = 21'd29128;
         3'd7:    m = 21'd21400;
         default: m = 21'd1048576;
      endcase
      return m;
   endfunction

endpackage

### src/box_mean_filter_stream_core.sv
// ---------------------------------------------------------------------------
// Box mean filter stream core
// Streaming N x N box mean over raster-order 8-bit pixels, built around a
// column-addressed line RAM with one lane per buffered row.
// ---------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  req_     in         pixel in tdata, frame_start in tuser
//  rsp_     out        mean, center_row, center_col in tdata, last in tlast
//  csr_     in         register index and write data
//
// One pixel is accepted per clock while credits remain; each result passes
// through the line RAM read and the sum and reciprocal multiply stages.
// The line RAM is not cleared; reset only clears counters, registers and
// valid state, so no pixel is refused after reset.
// Results wait in an eight-entry FIFO; pixels are refused only while eight
// results are either queued or still in flight.
// ---------------------------------------------------------------------------
`include "box_mean_filter_stream_core_assert.svh"

module box_mean_filter_stream_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bmf_pkg::REQ_DATA_W-1:0]      req_tdata,   // [7:0] pixel
   input  logic [0:0]                          req_tuser,   // [0] frame_start
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bmf_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // mean, center_row, center_col
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bmf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bmf_pkg::CSR_DATA_W-1:0]      csr_data
);

   logic [bmf_pkg::N_W-1:0]     win_size_ff, win_size_in;
   logic [bmf_pkg::WIDTH_W-1:0] img_width_ff, img_width_in;
   logic [bmf_pkg::ROW_W-1:0]   img_height_ff, img_height_in;

   logic [bmf_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [bmf_pkg::COL_W-1:0]   col_ff, col_in;
   logic [1:0]                  mod3_ff, mod3_in;
   logic [1:0]                  mod4_ff, mod4_in;
   logic [2:0]                  mod5_ff, mod5_in;

   logic                        accept;
   logic                        frame_start;
   logic [bmf_pkg::PIX_W-1:0]   pixel;
   logic [bmf_pkg::N_W-1:0]     n_eff;
   logic [bmf_pkg::N_W-1:0]     span;
   logic [bmf_pkg::N_W-1:0]     half;
   logic [bmf_pkg::WIDTH_W-1:0] w_eff;
   logic [bmf_pkg::ROW_W-1:0]   h_eff;
   logic [bmf_pkg::ROW_W-1:0]   r;
   logic [bmf_pkg::COL_W-1:0]   c;
   logic [1:0]                  m3, m4;
   logic [2:0]                  m5;
   logic [bmf_pkg::WIDTH_W-1:0] col_inc;
   logic [bmf_pkg::ROW_W:0]     row_inc;
   logic                        col_last, row_last;
   logic [bmf_pkg::N_W-1:0]     wr_slot;
   logic [bmf_pkg::LANES-1:0]   wr_lanes;
   logic [bmf_pkg::LANES-1:0]   rd_mask;
   bmf_pkg::ctl_type            ctl0;

   logic [bmf_pkg::LANES-1:0][bmf_pkg::PIX_W-1:0] ram_rd_data;

   logic                        s1_valid_ff;
   logic [bmf_pkg::PIX_W-1:0]   s1_pix_ff;
   logic [bmf_pkg::LANES-1:0]   s1_mask_ff;
   bmf_pkg::ctl_type            s1_ctl_ff;
   logic [bmf_pkg::CS_W-1:0]    cs;

   logic                        res_valid;
   bmf_pkg::result_type         res;
   bmf_pkg::result_type         out_res;
   bmf_pkg::fifo_status_type    fifo_stat;

   logic [bmf_pkg::CNT_W-1:0]   credit_ff, credit_in;
   logic                        rsp_pop;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      win_size_in   = win_size_ff;
      img_width_in  = img_width_ff;
      img_height_in = img_height_ff;
      if (csr_valid) begin
         case (bmf_pkg::csr_index_type'(csr_index))
            bmf_pkg::CSR_WINDOW_SIZE: begin
               win_size_in = csr_data[bmf_pkg::N_W-1:0];
            end
            bmf_pkg::CSR_IMAGE_WIDTH: begin
               img_width_in = csr_data[bmf_pkg::WIDTH_W-1:0];
            end
            bmf_pkg::CSR_IMAGE_HEIGHT: begin
               img_height_in = csr_data[bmf_pkg::ROW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Input stage: position, window geometry and line RAM lanes.
   assign accept      = req_tvalid && req_tready;
   assign frame_start = req_tuser[0];
   assign pixel       = req_tdata[bmf_pkg::PIX_W-1:0];

   assign n_eff = (win_size_ff == '0) ? bmf_pkg::N_W'(1) : win_size_ff;
   assign span  = n_eff - 1'b1;
   assign half  = span >> 1;
   assign h_eff = (img_height_ff == '0) ? bmf_pkg::ROW_W'(1) : img_height_ff;

   always_comb begin
      if (img_width_ff == '0) begin
         w_eff = bmf_pkg::WIDTH_W'(1);
      end else if (img_width_ff > bmf_pkg::WIDTH_W'(bmf_pkg::MAX_WIDTH)) begin
         w_eff = bmf_pkg::WIDTH_W'(bmf_pkg::MAX_WIDTH);
      end else begin
         w_eff = img_width_ff;
      end
   end

   assign r  = frame_start ? '0 : row_ff;
   assign c  = frame_start ? '0 : col_ff;
   assign m3 = frame_start ? '0 : mod3_ff;
   assign m4 = frame_start ? '0 : mod4_ff;
   assign m5 = frame_start ? '0 : mod5_ff;

   assign col_inc  = {1'b0, c} + 1'b1;
   assign row_inc  = {1'b0, r} + 1'b1;
   assign col_last = (col_inc >= w_eff);
   assign row_last = (row_inc >= {1'b0, h_eff});

   always_comb begin
      row_in  = r;
      col_in  = c;
      mod3_in = m3;
      mod4_in = m4;
      mod5_in = m5;
      if (col_last) begin
         col_in = '0;
         if (row_last) begin
            row_in  = '0;
            mod3_in = '0;
            mod4_in = '0;
            mod5_in = '0;
         end else begin
            row_in  = row_inc[bmf_pkg::ROW_W-1:0];
            mod3_in = (m3 == 2'd2) ? 2'd0 : m3 + 1'b1;
            mod4_in = m4 + 1'b1;
            mod5_in = (m5 == 3'd4) ? 3'd0 : m5 + 1'b1;
         end
      end else begin
         col_in = col_inc[bmf_pkg::COL_W-1:0];
      end
   end

   // Lane of the current row is row modulo span, taken from running residues.
   always_comb begin
      case (span)
         3'd2:    wr_slot = {2'b00, m4[0]};
         3'd3:    wr_slot = {1'b0, m3};
         3'd4:    wr_slot = {1'b0, m4};
         3'd5:    wr_slot = m5;
         3'd6:    wr_slot = (m3[0] == m4[0]) ? {1'b0, m3} : {1'b0, m3} + 3'd3;
         default: wr_slot = '0;
      endcase
   end

   assign wr_lanes = (accept && (span != '0)) ?
                     (bmf_pkg::LANES'(1) << wr_slot) : '0;

   always_comb begin
      for (int l = 0; l < bmf_pkg::LANES; l++) begin
         rd_mask[l] = (bmf_pkg::N_W'(l) < span) && (bmf_pkg::ROW_W'(l) < r);
      end
   end

   assign ctl0.emit       = (bmf_pkg::ROW_W'(span) <= r) && (bmf_pkg::COL_W'(span) <= c);
   assign ctl0.n          = n_eff;
   assign ctl0.center_row = r - bmf_pkg::ROW_W'(half);
   assign ctl0.center_col = c - bmf_pkg::COL_W'(half);
   assign ctl0.last       = row_last && col_last;

   bmf_line_ram u_line_ram (
      .clock    (clock),
      .rd_en    (accept),
      .addr     (c),
      .wr_lanes (wr_lanes),
      .wr_data  (pixel),
      .rd_data  (ram_rd_data)
   );

   // Column sum stage.
   always_comb begin
      cs = bmf_pkg::CS_W'(s1_pix_ff);
      for (int l = 0; l < bmf_pkg::LANES; l++) begin
         if (s1_mask_ff[l]) begin
            cs = cs + bmf_pkg::CS_W'(ram_rd_data[l]);
         end
      end
   end

   bmf_window_acc u_window_acc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_cs     (cs),
      .in_ctl    (s1_ctl_ff),
      .out_valid (res_valid),
      .out_res   (res)
   );

   bmf_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .pop_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_res),
      .status    (fifo_stat)
   );

   assign rsp_tdata = {(bmf_pkg::RSP_DATA_W - bmf_pkg::RSP_FIELD_W)'(0),
                       out_res.center_col, out_res.center_row, out_res.mean};
   assign rsp_tlast = out_res.last;

   // Credits count results queued or in flight, so the FIFO never overflows.
   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign req_tready = (credit_ff < bmf_pkg::CNT_W'(bmf_pkg::FIFO_DEPTH));

   always_comb begin
      credit_in = credit_ff;
      if ((accept && ctl0.emit) && !rsp_pop) begin
         credit_in = credit_ff + 1'b1;
      end else if (rsp_pop && !(accept && ctl0.emit)) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff   <= bmf_pkg::N_W'(3);
         img_width_ff  <= bmf_pkg::WIDTH_W'(1024);
         img_height_ff <= bmf_pkg::ROW_W'(1024);
         row_ff        <= '0;
         col_ff        <= '0;
         mod3_ff       <= '0;
         mod4_ff       <= '0;
         mod5_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         credit_ff     <= '0;
      end else begin
         win_size_ff   <= win_size_in;
         img_width_ff  <= img_width_in;
         img_height_ff <= img_height_in;
         credit_ff     <= credit_in;
         s1_valid_ff   <= accept;
         if (accept) begin
            row_ff  <= row_in;
            col_ff  <= col_in;
            mod3_ff <= mod3_in;
            mod4_ff <= mod4_in;
            mod5_ff <= mod5_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= pixel;
         s1_mask_ff <= rd_mask;
         s1_ctl_ff  <= ctl0;
      end
   end

   `BMF_ASSERT_SAME(a_credit_bound, clock, reset, 1'b1, credit_ff <= bmf_pkg::CNT_W'(bmf_pkg::FIFO_DEPTH), "credit count exceeds FIFO depth")
   `BMF_ASSERT_SAME(a_no_push_full, clock, reset, res_valid, !fifo_stat.full, "result pushed into a full FIFO")
   `BMF_ASSERT_SAME(a_valid_has_credit, clock, reset, rsp_tvalid, credit_ff != '0, "result beat offered with no credit held")
   `BMF_ASSERT_NEXT(a_credit_up, clock, reset, accept && ctl0.emit && !rsp_pop, credit_ff == $past(credit_ff) + 1'b1, "credit not taken for an emitting pixel")

endmodule

### src/bmf_line_ram.sv
// ---------------------------------------------------------------------------
// Box mean filter line RAM
// One word per column holding one pixel lane for each buffered row, with
// per-lane write enables and a registered read (read-first on collisions).
// ---------------------------------------------------------------------------
module bmf_line_ram (
   input  logic                                       clock,
   input  logic                                       rd_en,
   input  logic [bmf_pkg::COL_W-1:0]                  addr,
   input  logic [bmf_pkg::LANES-1:0]                  wr_lanes,
   input  logic [bmf_pkg::PIX_W-1:0]                  wr_data,
   output logic [bmf_pkg::LANES-1:0][bmf_pkg::PIX_W-1:0] rd_data
);

   logic [bmf_pkg::LANES-1:0][bmf_pkg::PIX_W-1:0] mem [bmf_pkg::MAX_WIDTH];

   always_ff @(posedge clock) begin
      for (int l = 0; l < bmf_pkg::LANES; l++) begin
         if (wr_lanes[l]) begin
            mem[addr][l] <= wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[addr];
      end
   end

endmodule

### src/bmf_window_acc.sv
// ---------------------------------------------------------------------------
// Box mean filter window accumulator
// Shifts column sums, adds the active window and divides by the window area
// through a reciprocal multiply, one stage each.
// ---------------------------------------------------------------------------
module bmf_window_acc (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [bmf_pkg::CS_W-1:0]   in_cs,
   input  bmf_pkg::ctl_type           in_ctl,
   output logic                       out_valid,
   output bmf_pkg::result_type        out_res
);

   logic [bmf_pkg::CS_W-1:0]   colsum_ff [bmf_pkg::MAX_WINDOW];
   logic                       a_valid_ff;
   bmf_pkg::ctl_type           a_ctl_ff;
   logic                       b_valid_ff;
   bmf_pkg::ctl_type           b_ctl_ff;
   logic [bmf_pkg::SUM_W-1:0]  sum_ff;
   logic [bmf_pkg::SUM_W-1:0]  sum_in;
   logic                       c_valid_ff;
   bmf_pkg::result_type        res_ff;
   logic [bmf_pkg::PROD_W-1:0] prod;

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < bmf_pkg::MAX_WINDOW; k++) begin
         if (bmf_pkg::N_W'(k) < a_ctl_ff.n) begin
            sum_in = sum_in + bmf_pkg::SUM_W'(colsum_ff[k]);
         end
      end
   end

   assign prod = bmf_pkg::PROD_W'(sum_ff) * bmf_pkg::PROD_W'(bmf_pkg::recip(b_ctl_ff.n));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         for (int k = 0; k < bmf_pkg::MAX_WINDOW; k++) begin
            colsum_ff[k] <= '0;
         end
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff && b_ctl_ff.emit;
         if (in_valid) begin
            colsum_ff[0] <= in_cs;
            for (int k = 1; k < bmf_pkg::MAX_WINDOW; k++) begin
               colsum_ff[k] <= colsum_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ctl_ff <= in_ctl;
      b_ctl_ff <= a_ctl_ff;
      sum_ff   <= sum_in;
      res_ff.mean       <= prod[bmf_pkg::RECIP_SHIFT +: bmf_pkg::PIX_W];
      res_ff.center_row <= b_ctl_ff.center_row;
      res_ff.center_col <= b_ctl_ff.center_col;
      res_ff.last       <= b_ctl_ff.last;
   end

   assign out_valid = c_valid_ff;
   assign out_res   = res_ff;

endmodule

### src/bmf_result_fifo.sv
// ---------------------------------------------------------------------------
// Box mean filter result FIFO
// Small register FIFO that holds finished results until the sink takes them.
// ---------------------------------------------------------------------------
module bmf_result_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  bmf_pkg::result_type      push_data,
   input  logic                     pop_ready,
   output logic                     out_valid,
   output bmf_pkg::result_type      out_data,
   output bmf_pkg::fifo_status_type status
);

   bmf_pkg::result_type          mem [bmf_pkg::FIFO_DEPTH];
   logic [bmf_pkg::FIFO_AW-1:0]  wr_ptr_ff;
   logic [bmf_pkg::FIFO_AW-1:0]  rd_ptr_ff;
   logic [bmf_pkg::CNT_W-1:0]    count_ff;
   logic [bmf_pkg::CNT_W-1:0]    count_in;
   logic                         pop;

   assign out_valid    = (count_ff != '0);
   assign out_data     = mem[rd_ptr_ff];
   assign pop          = out_valid && pop_ready;
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == bmf_pkg::CNT_W'(bmf_pkg::FIFO_DEPTH));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sim/box_mean_filter_stream_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Box mean filter stream core testbench
// Streams raster-order pixel frames through the core under a series of window,
// width and height settings, with random idling on both channels. A scoreboard
// predicts every window mean with its center coordinates and frame-end flag and
// checks each result beat against it in order.
// ---------------------------------------------------------------------------
module box_mean_filter_stream_core_tb;
   import bmf_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 20;

   typedef enum int {
      PAT_NOISE    = 0,
      PAT_WHITE    = 1,
      PAT_BLACK    = 2,
      PAT_EXTREMES = 3,
      PAT_MIXED    = 4
   } pixel_pattern_e;

   typedef enum int {
      IDLE_NONE     = 0,
      IDLE_SENDER   = 1,
      IDLE_RECEIVER = 2,
      IDLE_BOTH     = 3
   } idle_mode_e;

   class mean_scoreboard;
      bit [PIX_W-1:0]   line_ram [LANES*MAX_WIDTH];
      int unsigned      col_sums [MAX_WINDOW];
      int unsigned      row_pos;
      int unsigned      col_pos;
      bit [N_W-1:0]     win_reg;
      bit [WIDTH_W-1:0] width_reg;
      bit [ROW_W-1:0]   height_reg;
      result_type       pending [$];
      int               errors;

      function new();
         win_reg    = 3;
         width_reg  = 1024;
         height_reg = 1024;
         row_pos    = 0;
         col_pos    = 0;
         errors     = 0;
      endfunction

      function void write_reg(csr_index_type idx, bit [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_WINDOW_SIZE:  win_reg = value[N_W-1:0];
            CSR_IMAGE_WIDTH:  width_reg = value[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_reg = value[ROW_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_pixel(bit [PIX_W-1:0] pix, bit frame_start);
         int unsigned n, w, h, r, c, span, cs, sum;
         result_type  res;
         n = (win_reg == 0) ? 1 : win_reg;
         w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
         h = (height_reg == 0) ? 1 : height_reg;
         if (frame_start) begin
            row_pos = 0;
            col_pos = 0;
         end
         r = row_pos;
         c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
         span = n - 1;
         cs = pix;
         if (span > 0) begin
            // The lane of row r-span is the lane of row r, so it is read before it is written.
            for (int k = 1; k <= span; k++)
               if (r >= k)
                  cs += line_ram[((r - k) % span) * MAX_WIDTH + c];
            line_ram[(r % span) * MAX_WIDTH + c] = pix;
         end
         for (int k = MAX_WINDOW - 1; k > 0; k--)
            col_sums[k] = col_sums[k - 1];
         col_sums[0] = cs;
         sum = 0;
         for (int k = 0; k < n; k++)
            sum += col_sums[k];
         if (r >= span && c >= span) begin
            res.mean       = PIX_W'(sum / (n * n));
            res.center_row = ROW_W'(r - span / 2);
            res.center_col = COL_W'(c - span / 2);
            res.last       = (r + 1 >= h) && (c + 1 >= w);
            pending.push_back(res);
         end
         if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
         end
      endfunction

      function void compare(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         end
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data, logic last_bit);
         result_type res;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: result beat with none expected, mean %0d row %0d col %0d",
                     $time, data[7:0], data[23:8], data[33:24]);
            return;
         end
         res = pending.pop_front();
         compare("mean", res.mean, data[7:0]);
         compare("center_row", res.center_row, data[23:8]);
         compare("center_col", res.center_col, data[33:24]);
         compare("last", res.last, last_bit);
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [0:0]              req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   mean_scoreboard sb = new();
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_len = 0;
   int phase_no = 0;
   int cycle_count = 0;

   box_mean_filter_stream_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready)
            sb.note_pixel(req_tdata[7:0], req_tuser[0]);
      end
   end

   // A requested hold-off keeps the result channel stalled until hold_len runs down to zero.
   always @(negedge clock) begin
      if (hold_len > 0) begin
         rsp_tready <= 1'b0;
         hold_len = hold_len - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   task automatic send_pixel(logic [PIX_W-1:0] pix, logic fs);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= fs;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_regs(int n, int w, int h);
      csr_index_type idx [3];
      int unsigned   vals [3];
      idx  = '{CSR_WINDOW_SIZE, CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT};
      vals = '{n, w, h};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= CSR_DATA_W'(vals[i]);
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
         sb.write_reg(idx[i], CSR_DATA_W'(vals[i]));
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (sb.pending.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(int n, int w, int h, int count, bit fresh,
                            pixel_pattern_e pat_sel, bit pressure);
      pixel_pattern_e pat;
      idle_mode_e     mode;
      logic [PIX_W-1:0] pix;
      logic           fs;
      bit             origin;
      int             pick;
      wait_drained();
      write_regs(n, w, h);
      mode = idle_mode_e'(phase_no % 4);
      phase_no++;
      send_idle_pct = (mode == IDLE_SENDER) ? 53 : (mode == IDLE_BOTH) ? 9 : 0;
      rsp_stall_pct = (mode == IDLE_RECEIVER) ? 53 : (mode == IDLE_BOTH) ? 9 : 0;
      pat = PAT_NOISE;
      for (int i = 0; i < count; i++) begin
         if (pressure && i == count / 4)
            hold_len = 300;
         if (pressure && i == (count * 3) / 4) begin
            req_tvalid <= 1'b0;
            do
               @(negedge clock);
            while (sb.pending.size() != 0);
         end
         origin = (sb.row_pos == 0) && (sb.col_pos == 0);
         if (origin || i == 0) begin
            pick = $urandom_range(0, 5);
            if (pat_sel != PAT_MIXED)
               pat = pat_sel;
            else
               pat = (pick < 3) ? PAT_NOISE : pixel_pattern_e'(pick - 2);
         end
         case (pat)
            PAT_WHITE:    pix = 8'hFF;
            PAT_BLACK:    pix = 8'h00;
            PAT_EXTREMES: pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:      pix = PIX_W'($urandom);
         endcase
         if (fresh && i == 0)
            fs = 1'b1;
         else if (origin)
            fs = $urandom_range(0, 1);
         else
            fs = ($urandom_range(0, 299) == 0);
         send_pixel(pix, fs);
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      logic [PIX_W-1:0] dir_pix [17];
      bit               dir_fs [17];
      dir_pix = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd127, 8'd254, 8'd85, 8'd170, 8'd0,
                  8'd255, 8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64};
      dir_fs  = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A window size of zero acts as one, so every pixel gives a result.
      write_regs(0, 7, 2);
      @(negedge clock);
      for (int i = 0; i < 17; i++)
         send_pixel(dir_pix[i], dir_fs[i]);
      req_tvalid <= 1'b0;

      run_phase(3, 7, 7, 200, 1, PAT_MIXED, 0);
      run_phase(7, 7, 7, 98, 1, PAT_WHITE, 0);
      run_phase(7, 7, 9, 250, 1, PAT_MIXED, 0);
      run_phase(1, 9, 0, 60, 1, PAT_MIXED, 0);
      run_phase(2, 0, 5, 30, 1, PAT_MIXED, 0);
      run_phase(4, 3, 6, 40, 1, PAT_MIXED, 0);
      run_phase(6, 16, 8, 300, 1, PAT_MIXED, 0);
      run_phase(1, 10, 5, 400, 1, PAT_MIXED, 1);
      run_phase(2, 2047, 2, 2048, 1, PAT_MIXED, 0);
      // The second setting shrinks the frame under counters left mid-frame.
      run_phase(3, 20, 12, 150, 1, PAT_MIXED, 0);
      run_phase(3, 9, 4, 150, 0, PAT_MIXED, 0);
      run_phase(3, 8, 65535, 100, 1, PAT_MIXED, 0);
      repeat (4)
         run_phase($urandom_range(0, 7), $urandom_range(7, 24), $urandom_range(1, 12),
                   120, 1, PAT_MIXED, 0);

      wait_drained();
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
